// ----- hw/rtl/tkps_pkg.sv -----
// Package for the top-k spectral peak search block.
// Holds field widths, parameter defaults, payload structs and the sequencer state type.
// No dependencies.
`default_nettype none

package tkps_pkg;

  localparam int SEARCH_BINS_DEF = 64;
  localparam int MAX_PEAKS_DEF   = 8;

  localparam int MAG_W     = 16;
  localparam int BIN_W     = 7;
  localparam int RANK_W    = 3;
  localparam int CNT_W     = 4;
  localparam int FIRST_POS = 2;

  localparam logic [CNT_W-1:0] PEAK_COUNT_RST = 4'd3;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             frame_last;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]  peak_bin;
    logic [RANK_W-1:0] peak_rank;
    logic              last_peak;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } tkps_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tkps_bin_ram.sv -----
// Bin magnitude RAM: one write port, one read port with registered read data.
// Depends on tkps_pkg for the magnitude width.
`default_nettype none

module tkps_bin_ram #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic [tkps_pkg::MAG_W-1:0] wr_data,
  input  wire logic                    rd_en,
  input  wire logic [AW-1:0]           rd_addr,
  output      logic [tkps_pkg::MAG_W-1:0] rd_data
);
  import tkps_pkg::*;

  logic [MAG_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/top_k_spectral_peak_search.sv -----
// Top level of the top-k spectral peak search block: frame loader, scan sequencer, result register.
// Depends on tkps_pkg and tkps_bin_ram.
//
// A frame streams in one magnitude per transaction, one per cycle while in_ready is high;
// positions 0 and 1 are dropped and positions 2 to SEARCH_BINS+1 go to the bin RAM. The
// transaction marked frame_last starts the search unless the effective peak count is zero,
// and input is not ready until the frame's last peak has been loaded into the output
// register. Each peak is one pass of a single compare unit over the RAM read port, and the
// effective peak count saturates at MAX_PEAKS (and at 15). Bins that were not received in
// the frame read as zero through the position counter, so there is no clearing pass; chosen
// flags are flip-flops cleared at frame end.
`default_nettype none

module top_k_spectral_peak_search #(
  parameter int SEARCH_BINS = tkps_pkg::SEARCH_BINS_DEF,
  parameter int MAX_PEAKS   = tkps_pkg::MAX_PEAKS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire tkps_pkg::in_item_t        in_data,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      tkps_pkg::out_item_t       out_data,
  input  wire logic                      cfg_we,
  input  wire logic [tkps_pkg::CNT_W-1:0] cfg_wdata
);
  import tkps_pkg::*;

  localparam int IW  = $clog2(SEARCH_BINS);
  localparam int FPW = $clog2(SEARCH_BINS + 3);
  localparam logic [FPW-1:0] POS_FIRST = FPW'(FIRST_POS);
  localparam logic [FPW-1:0] POS_END   = FPW'(SEARCH_BINS + FIRST_POS);
  localparam logic [IW-1:0]  IDX_LAST  = IW'(SEARCH_BINS - 1);
  localparam int MAX_SAT_I = (MAX_PEAKS > 15) ? 15 : MAX_PEAKS;
  localparam logic [CNT_W-1:0] MAX_SAT = CNT_W'(MAX_SAT_I);

  tkps_state_t       state_r, state_nxt;
  logic [FPW-1:0]    frame_pos_r, frame_pos_nxt;
  logic [SEARCH_BINS-1:0] chosen_r, chosen_nxt;
  logic [CNT_W-1:0]  peak_count_r;
  logic [CNT_W-1:0]  rank_r, rank_nxt;
  logic              rd_act_r, rd_act_nxt;
  logic [IW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              cmp_vld_r;
  logic [IW-1:0]     cmp_idx_r;
  logic              found_r, found_nxt;
  logic [IW-1:0]     best_r, best_nxt;
  logic [MAG_W-1:0]  best_mag_r, best_mag_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              in_acc;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [MAG_W-1:0]  rd_data;
  logic              rd_filled;
  logic [MAG_W-1:0]  cmp_mag;
  logic              take;
  logic [CNT_W-1:0]  cnt_eff;
  logic              emit_go;
  logic              is_last;
  logic [BIN_W-1:0]  pos_w;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign wr_en   = in_acc && (frame_pos_r >= POS_FIRST) && (frame_pos_r < POS_END);
  assign wr_addr = IW'(frame_pos_r - POS_FIRST);

  tkps_bin_ram #(
    .DEPTH (SEARCH_BINS)
  ) u_bin_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.magnitude),
    .rd_en   (rd_act_r),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  assign rd_filled = ((FPW'(cmp_idx_r) + POS_FIRST) < frame_pos_r);
  assign cmp_mag   = rd_filled ? rd_data : '0;
  assign take      = cmp_vld_r && !chosen_r[cmp_idx_r] && (!found_r || (cmp_mag > best_mag_r));
  assign cnt_eff   = (peak_count_r > MAX_SAT) ? MAX_SAT : peak_count_r;
  assign emit_go   = !out_valid_r || out_ready;
  assign is_last   = ((rank_r + CNT_W'(1)) == cnt_eff);
  assign pos_w     = BIN_W'(32'(best_r) + 32'(FIRST_POS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      frame_pos_r  <= '0;
      chosen_r     <= '0;
      peak_count_r <= PEAK_COUNT_RST;
      rank_r       <= '0;
      rd_act_r     <= 1'b0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_pos_r <= frame_pos_nxt;
      chosen_r    <= chosen_nxt;
      rank_r      <= rank_nxt;
      rd_act_r    <= rd_act_nxt;
      cmp_vld_r   <= rd_act_r;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        peak_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    cmp_idx_r  <= rd_idx_r;
    best_r     <= best_nxt;
    best_mag_r <= best_mag_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    frame_pos_nxt = frame_pos_r;
    chosen_nxt    = chosen_r;
    rank_nxt      = rank_r;
    rd_act_nxt    = rd_act_r;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_mag_nxt  = best_mag_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (take) begin
      found_nxt    = 1'b1;
      best_nxt     = cmp_idx_r;
      best_mag_nxt = cmp_mag;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (frame_pos_r < POS_END) begin
            frame_pos_nxt = frame_pos_r + FPW'(1);
          end
          if (in_data.frame_last) begin
            if (cnt_eff == '0) begin
              frame_pos_nxt = '0;
            end else begin
              state_nxt  = ST_SCAN;
              rank_nxt   = '0;
              rd_act_nxt = 1'b1;
              rd_idx_nxt = '0;
              found_nxt  = 1'b0;
              best_nxt   = '0;
            end
          end
        end
      end
      ST_SCAN: begin
        if (rd_act_r) begin
          if (rd_idx_r == IDX_LAST) begin
            rd_act_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + IW'(1);
          end
        end
        if (cmp_vld_r && (cmp_idx_r == IDX_LAST)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.peak_bin  = pos_w;
          out_data_nxt.peak_rank = rank_r[RANK_W-1:0];
          out_data_nxt.last_peak = is_last;
          chosen_nxt[best_r]     = 1'b1;
          rank_nxt               = rank_r + CNT_W'(1);
          if (is_last) begin
            state_nxt     = ST_IDLE;
            chosen_nxt    = '0;
            frame_pos_nxt = '0;
          end else begin
            state_nxt  = ST_SCAN;
            rd_act_nxt = 1'b1;
            rd_idx_nxt = '0;
            found_nxt  = 1'b0;
            best_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_frame_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frame_pos_r <= POS_END)
    else $error("frame position beyond saturation");

  a_last_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.frame_last && (cnt_eff != '0)) |=> (state_r == ST_SCAN))
    else $error("frame end did not start a scan");

  a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result loaded outside emit");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last_peak && $past(state_r == ST_EMIT && emit_go))
      |-> (state_r == ST_IDLE && chosen_r == '0))
    else $error("frame state not cleared after last peak");

endmodule

`default_nettype wire
